// ===== sv/least_load_gate_selector_core_assert.svh =====
// assertion macros shared by the selector rtl
`ifndef LEAST_LOAD_GATE_SELECTOR_CORE_ASSERT_SVH
`define LEAST_LOAD_GATE_SELECTOR_CORE_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define LLGS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define LLGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/llgs_pkg.sv =====
// types and constants of the least-load selector
`default_nettype none

package llgs_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int MODE_W   = 2;
    localparam int HANDLE_W = 16;
    localparam int PORT_W   = 16;
    localparam int LOAD_W   = 24;
    localparam int CONN_W   = 20;
    localparam int STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET = 2'd0,
        MODE_DEL = 2'd1,
        MODE_UPD = 2'd2,
        MODE_REQ = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_SERVER = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_LOOK,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [PORT_W-1:0]   port;
        logic [LOAD_W-1:0]   load;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        status_t             status;
        logic [CONN_W-1:0]   reply_conn;
        logic [HANDLE_W-1:0] handle;
        logic [PORT_W-1:0]   port;
        logic [LOAD_W-1:0]   load;
    } result_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
    } ram_cmd_t;

endpackage

`default_nettype wire

// ===== sv/llgs_ram.sv =====
// simple dual-port ram, one write and one registered read per cycle
`default_nettype none

module llgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/llgs_seq.sv =====
// table sequencer: lookup, delete shift and least-load scan over the entry ram
`default_nettype none
`include "least_load_gate_selector_core_assert.svh"

module llgs_seq (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [llgs_pkg::MODE_W-1:0]       s_mode,
    input  wire logic [llgs_pkg::HANDLE_W-1:0]     s_gate_handle,
    input  wire logic [llgs_pkg::PORT_W-1:0]       s_gate_port,
    input  wire logic [llgs_pkg::LOAD_W-1:0]       s_gate_load,
    input  wire logic [llgs_pkg::CONN_W-1:0]       s_conn_id,
    output logic                                   res_vld,
    input  wire logic                              res_rdy,
    output llgs_pkg::result_t                      res,
    output llgs_pkg::ram_cmd_t                     ram_cmd,
    input  wire llgs_pkg::entry_t                  rd_data
);

    import llgs_pkg::*;

    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [PORT_W-1:0]   port_reg, port_next;
    logic [LOAD_W-1:0]   load_reg, load_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    mod_reg, mod_next;
    logic [ADDR_W-1:0]   iss_addr_reg, iss_addr_next;
    logic [CNT_W-1:0]    iss_left_reg, iss_left_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [ADDR_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                best_vld_reg, best_vld_next;
    entry_t              best_reg, best_next;
    logic [ADDR_W-1:0]   best_idx_reg, best_idx_next;
    result_t             res_reg, res_next;

    logic             accept;
    logic             issue;
    logic             look_hit;
    logic             look_end;
    logic             shift_end;
    logic             scan_end;
    logic             mod_done;
    logic             found_last;
    logic [CNT_W-1:0] rd_idx_inc;
    logic [CNT_W-1:0] iss_inc;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_ready && s_valid;
    assign res_vld  = (state_reg == S_DONE);
    assign res      = res_reg;

    assign rd_idx_inc = CNT_W'(rd_idx_reg) + CNT_W'(1);
    assign iss_inc    = CNT_W'(iss_addr_reg) + CNT_W'(1);
    assign found_last = (rd_idx_inc == cnt_reg);

    assign look_hit  = (state_reg == S_LOOK) && rd_vld_reg && (rd_data.handle == handle_reg);
    assign look_end  = (state_reg == S_LOOK)
                       && (look_hit || ((iss_left_reg == '0) && !rd_vld_reg));
    assign shift_end = (state_reg == S_SHIFT) && (iss_left_reg == '0) && !rd_vld_reg;
    assign scan_end  = (state_reg == S_SCAN) && (iss_left_reg == '0) && !rd_vld_reg;
    assign mod_done  = (state_reg == S_MOD) && (mod_reg < cnt_reg);
    assign issue     = (((state_reg == S_LOOK) && !look_hit) || (state_reg == S_SHIFT)
                        || (state_reg == S_SCAN)) && (iss_left_reg != '0);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (mode_t'(s_mode) != MODE_REQ) begin
                        state_next = S_LOOK;
                    end else if (cnt_reg == '0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    state_next = S_SCAN;
                end
            end
            S_LOOK: begin
                if (look_end) begin
                    if ((mode_reg == MODE_DEL) && look_hit && !found_last) begin
                        state_next = S_SHIFT;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SHIFT: begin
                if (shift_end) begin
                    state_next = S_DONE;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (res_rdy) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and ram access
    always_comb begin
        mode_next     = mode_reg;
        handle_next   = handle_reg;
        port_next     = port_reg;
        load_next     = load_reg;
        cnt_next      = cnt_reg;
        ptr_next      = ptr_reg;
        mod_next      = mod_reg;
        iss_addr_next = iss_addr_reg;
        iss_left_next = iss_left_reg;
        best_vld_next = best_vld_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        res_next      = res_reg;
        rd_vld_next   = issue;
        rd_idx_next   = iss_addr_reg;

        ram_cmd         = '0;
        ram_cmd.rd_en   = issue;
        ram_cmd.rd_addr = iss_addr_reg;

        if (issue) begin
            iss_left_next = iss_left_reg - CNT_W'(1);
            if ((state_reg == S_SCAN) && (iss_inc == cnt_reg)) begin
                iss_addr_next = '0;
            end else begin
                iss_addr_next = ADDR_W'(iss_inc);
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    mode_next     = mode_t'(s_mode);
                    handle_next   = s_gate_handle;
                    port_next     = s_gate_port;
                    load_next     = s_gate_load;
                    mod_next      = ptr_reg;
                    iss_addr_next = '0;
                    iss_left_next = cnt_reg;
                    best_vld_next = 1'b0;
                    res_next      = '0;
                    if (mode_t'(s_mode) == MODE_REQ) begin
                        res_next.reply_conn = s_conn_id;
                        if (cnt_reg == '0) begin
                            res_next.status = ST_NO_SERVER;
                        end
                    end
                end
            end
            S_MOD: begin
                // start index is the pointer reduced modulo the entry count
                if (mod_done) begin
                    iss_addr_next = ADDR_W'(mod_reg);
                    iss_left_next = cnt_reg;
                end else begin
                    mod_next = mod_reg - cnt_reg;
                end
            end
            S_LOOK: begin
                if (look_end) begin
                    case (mode_reg)
                        MODE_SET, MODE_UPD: begin
                            ram_cmd.wr_data.handle = handle_reg;
                            ram_cmd.wr_data.load   = load_reg;
                            if (look_hit) begin
                                ram_cmd.wr_en          = 1'b1;
                                ram_cmd.wr_addr        = rd_idx_reg;
                                ram_cmd.wr_data.port   = (mode_reg == MODE_SET) ? port_reg
                                                                                : rd_data.port;
                            end else if (cnt_reg == CNT_W'(TABLE_DEPTH)) begin
                                res_next.status = ST_FULL;
                            end else begin
                                ram_cmd.wr_en          = 1'b1;
                                ram_cmd.wr_addr        = ADDR_W'(cnt_reg);
                                ram_cmd.wr_data.port   = (mode_reg == MODE_SET) ? port_reg
                                                                                : '0;
                                cnt_next               = cnt_reg + CNT_W'(1);
                            end
                        end
                        MODE_DEL: begin
                            if (!look_hit) begin
                                res_next.status = ST_NOT_FOUND;
                            end else if (found_last) begin
                                cnt_next = cnt_reg - CNT_W'(1);
                            end else begin
                                iss_addr_next = ADDR_W'(rd_idx_inc);
                                iss_left_next = cnt_reg - rd_idx_inc;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // entry read at index i lands at index i-1
                if (rd_vld_reg) begin
                    ram_cmd.wr_en   = 1'b1;
                    ram_cmd.wr_addr = rd_idx_reg - ADDR_W'(1);
                    ram_cmd.wr_data = rd_data;
                end
                if (shift_end) begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_SCAN: begin
                if (rd_vld_reg && (!best_vld_reg || (rd_data.load < best_reg.load))) begin
                    best_vld_next = 1'b1;
                    best_next     = rd_data;
                    best_idx_next = rd_idx_reg;
                end
                if (scan_end) begin
                    res_next.handle = best_reg.handle;
                    res_next.port   = best_reg.port;
                    res_next.load   = best_reg.load;
                    ptr_next        = CNT_W'(best_idx_reg) + CNT_W'(1);
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ptr_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ptr_reg    <= ptr_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        handle_reg    <= handle_next;
        port_reg      <= port_next;
        load_reg      <= load_next;
        mod_reg       <= mod_next;
        iss_addr_reg  <= iss_addr_next;
        iss_left_reg  <= iss_left_next;
        rd_idx_reg    <= rd_idx_next;
        best_vld_reg  <= best_vld_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        res_reg       <= res_next;
    end

    `LLGS_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CNT_W'(TABLE_DEPTH), "entry count beyond table")
    `LLGS_ASSERT_ALWAYS(a_ptr_bound, ptr_reg <= CNT_W'(TABLE_DEPTH), "pointer beyond table")
    `LLGS_ASSERT_ALWAYS(a_rd_owner,
        !rd_vld_reg || state_reg == S_LOOK || state_reg == S_SHIFT || state_reg == S_SCAN,
        "read data returned outside a walk")

endmodule

`default_nettype wire

// ===== sv/least_load_gate_selector_core.sv =====
// top level of the least-load server selector
`default_nettype none
`include "least_load_gate_selector_core_assert.svh"

// Least-load server selector. A table of up to 16 servers (handle, port, load)
// lives in a single simple dual-port entry ram with a registered read.
// Each input beat sets an entry, deletes one by handle (later entries shift
// down), updates a load (adding the entry with port 0 when absent) or requests
// a server; every input beat gives exactly one result beat. A request scans
// all n entries from the rotating pointer and returns the first least-loaded
// one, then moves the pointer past it; an empty table answers "no server".
// Set, update and delete first look the handle up, the single ram read port
// walking one entry per cycle; a delete hit below the last entry then shifts
// the later entries down. A request first reduces the pointer modulo n, then
// scans the entries, while an empty table answers without a scan. Deletes can
// leave the pointer above n. Items are handled one at a time; a new beat is
// taken whenever the sequencer is idle, even while a result beat waits in the
// output register. After reset no clearing pass is needed: the table is empty.
module least_load_gate_selector_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [llgs_pkg::MODE_W-1:0]       s_mode,
    input  wire logic [llgs_pkg::HANDLE_W-1:0]     s_gate_handle,
    input  wire logic [llgs_pkg::PORT_W-1:0]       s_gate_port,
    input  wire logic [llgs_pkg::LOAD_W-1:0]       s_gate_load,
    input  wire logic [llgs_pkg::CONN_W-1:0]       s_conn_id,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [llgs_pkg::STATUS_W-1:0]          m_status,
    output logic [llgs_pkg::CONN_W-1:0]            m_reply_conn,
    output logic [llgs_pkg::HANDLE_W-1:0]          m_chosen_handle,
    output logic [llgs_pkg::PORT_W-1:0]            m_chosen_port,
    output logic [llgs_pkg::LOAD_W-1:0]            m_chosen_load
);

    import llgs_pkg::*;

    // sequencer to output register
    logic     res_vld;
    logic     res_rdy;
    result_t  res;

    // entry ram traffic
    ram_cmd_t ram_cmd;
    entry_t   rd_data;

    // output register, filled from the sequencer result
    logic    m_valid_reg, m_valid_next;
    result_t out_reg, out_next;

    llgs_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_gate_handle (s_gate_handle),
        .s_gate_port   (s_gate_port),
        .s_gate_load   (s_gate_load),
        .s_conn_id     (s_conn_id),
        .res_vld       (res_vld),
        .res_rdy       (res_rdy),
        .res           (res),
        .ram_cmd       (ram_cmd),
        .rd_data       (rd_data)
    );

    llgs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_cmd.wr_en),
        .wr_addr (ram_cmd.wr_addr),
        .wr_data (ram_cmd.wr_data),
        .rd_en   (ram_cmd.rd_en),
        .rd_addr (ram_cmd.rd_addr),
        .rd_data (rd_data)
    );

    // the register takes a new result when empty or being drained this cycle
    assign res_rdy = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        out_next     = out_reg;
        if (res_vld && res_rdy) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = out_reg.status;
    assign m_reply_conn    = out_reg.reply_conn;
    assign m_chosen_handle = out_reg.handle;
    assign m_chosen_port   = out_reg.port;
    assign m_chosen_load   = out_reg.load;

    // a finished result waits unchanged until the output register frees up
    `LLGS_ASSERT_NEXT(a_res_hold, res_vld && !res_rdy, res_vld && $stable(res),
        "pending result dropped or changed")
    // a transferred result shows on the output in the next cycle
    `LLGS_ASSERT_NEXT(a_res_load, res_vld && res_rdy, m_valid_reg,
        "result beat lost on its way out")
    // a stalled result beat keeps valid and payload until taken
    `LLGS_ASSERT_NEXT(a_out_hold, m_valid_reg && !m_ready, m_valid_reg && $stable(out_reg),
        "output beat dropped or changed while stalled")

endmodule

`default_nettype wire

// ===== verif/least_load_gate_selector_checker.sv =====
// scoreboard for the least-load selector: predicts each result beat and compares it
`timescale 1ns / 100ps

module least_load_gate_selector_checker
    import llgs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [MODE_W-1:0]   s_mode,
    input  logic [HANDLE_W-1:0] s_gate_handle,
    input  logic [PORT_W-1:0]   s_gate_port,
    input  logic [LOAD_W-1:0]   s_gate_load,
    input  logic [CONN_W-1:0]   s_conn_id,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [STATUS_W-1:0] m_status,
    input  logic [CONN_W-1:0]   m_reply_conn,
    input  logic [HANDLE_W-1:0] m_chosen_handle,
    input  logic [PORT_W-1:0]   m_chosen_port,
    input  logic [LOAD_W-1:0]   m_chosen_load,
    output int unsigned         fail_count,
    output int unsigned         pending,
    output int unsigned         checked,
    output int unsigned         n_ok,
    output int unsigned         n_no_server,
    output int unsigned         n_not_found,
    output int unsigned         n_full
);

    // shadow copy of the server table
    logic [HANDLE_W-1:0] srv_handle [TABLE_DEPTH];
    logic [PORT_W-1:0]   srv_port   [TABLE_DEPTH];
    logic [LOAD_W-1:0]   srv_load   [TABLE_DEPTH];
    int                  srv_count;
    logic [4:0]          scan_from;

    result_t     replies_due [$];
    int unsigned fails;
    int unsigned seen;
    int unsigned per_status [4];

    function automatic int find_server(input logic [HANDLE_W-1:0] h);
        for (int i = 0; i < srv_count; i++) begin
            if (srv_handle[i] == h) return i;
        end
        return srv_count;
    endfunction

    // applies one input beat to the shadow table and returns the reply it should give
    function automatic result_t serve_beat(input mode_t md, input logic [HANDLE_W-1:0] h,
                                           input logic [PORT_W-1:0] port,
                                           input logic [LOAD_W-1:0] load,
                                           input logic [CONN_W-1:0] conn);
        result_t r;
        int      idx;
        int      first;
        int      best;
        int      pos;
        r = '0;
        case (md)
            MODE_SET, MODE_UPD: begin
                idx = find_server(h);
                if (idx == srv_count && srv_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (idx == srv_count) begin
                        srv_handle[idx] = h;
                        srv_port[idx]   = '0;
                        srv_load[idx]   = '0;
                        srv_count++;
                    end
                    if (md == MODE_SET) srv_port[idx] = port;
                    srv_load[idx] = load;
                end
            end
            MODE_DEL: begin
                idx = find_server(h);
                if (idx == srv_count) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (int k = idx; k + 1 < srv_count; k++) begin
                        srv_handle[k] = srv_handle[k+1];
                        srv_port[k]   = srv_port[k+1];
                        srv_load[k]   = srv_load[k+1];
                    end
                    srv_count--;
                end
            end
            default: begin
                r.reply_conn = conn;
                if (srv_count == 0) begin
                    r.status = ST_NO_SERVER;
                end else begin
                    // first strictly smallest load, walking from the rotating start
                    first = int'(scan_from) % srv_count;
                    best  = first;
                    for (int k = 1; k < srv_count; k++) begin
                        pos = (first + k) % srv_count;
                        if (srv_load[pos] < srv_load[best]) best = pos;
                    end
                    r.handle  = srv_handle[best];
                    r.port    = srv_port[best];
                    r.load    = srv_load[best];
                    scan_from = 5'(best + 1);
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            srv_count = 0;
            scan_from = '0;
            replies_due.delete();
        end else begin
            // results first: a reply never belongs to the beat taken at the same edge
            if (m_valid && m_ready) begin
                seen++;
                if (replies_due.size() == 0) begin
                    $error("result beat with no reply outstanding");
                    fails++;
                end else begin
                    want = replies_due.pop_front();
                    per_status[want.status]++;
                    if (m_status !== want.status) begin
                        $error("m_status: expected %0d, got %0d", want.status, m_status);
                        fails++;
                    end
                    if (m_reply_conn !== want.reply_conn) begin
                        $error("m_reply_conn: expected %0h, got %0h",
                               want.reply_conn, m_reply_conn);
                        fails++;
                    end
                    if (m_chosen_handle !== want.handle) begin
                        $error("m_chosen_handle: expected %0h, got %0h",
                               want.handle, m_chosen_handle);
                        fails++;
                    end
                    if (m_chosen_port !== want.port) begin
                        $error("m_chosen_port: expected %0h, got %0h", want.port, m_chosen_port);
                        fails++;
                    end
                    if (m_chosen_load !== want.load) begin
                        $error("m_chosen_load: expected %0h, got %0h", want.load, m_chosen_load);
                        fails++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                replies_due.push_back(serve_beat(mode_t'(s_mode), s_gate_handle, s_gate_port,
                                                 s_gate_load, s_conn_id));
            end
        end
        fail_count  <= fails;
        pending     <= replies_due.size();
        checked     <= seen;
        n_ok        <= per_status[ST_OK];
        n_no_server <= per_status[ST_NO_SERVER];
        n_not_found <= per_status[ST_NOT_FOUND];
        n_full      <= per_status[ST_FULL];
    end

endmodule

// ===== verif/least_load_gate_selector_core_tb.sv =====
// top of the least-load selector testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module least_load_gate_selector_core_tb;
    import llgs_pkg::*;

    localparam int RANDOM_BEATS    = 1950;
    localparam int POOL_SIZE       = 24;    // a little more than the table, so it fills
    localparam int PHASE_LEN       = 150;   // beats per grow or drain phase
    localparam int QUIET_FROM      = 400;   // window of beats with no idling on either side
    localparam int QUIET_TO        = 750;
    localparam int HOLD_AT         = 1100;  // beat count at which the sink holds off
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 60;    // a few times the slowest beat

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [MODE_W-1:0]   s_mode        = '0;
    logic [HANDLE_W-1:0] s_gate_handle = '0;
    logic [PORT_W-1:0]   s_gate_port   = '0;
    logic [LOAD_W-1:0]   s_gate_load   = '0;
    logic [CONN_W-1:0]   s_conn_id     = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [CONN_W-1:0]   m_reply_conn;
    logic [HANDLE_W-1:0] m_chosen_handle;
    logic [PORT_W-1:0]   m_chosen_port;
    logic [LOAD_W-1:0]   m_chosen_load;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;
    int unsigned n_ok;
    int unsigned n_no_server;
    int unsigned n_not_found;
    int unsigned n_full;

    int unsigned         beats_sent = 0;
    bit                  quiet      = 1'b0;
    logic [HANDLE_W-1:0] pool_base;
    // handles from outside the pool sent in set or update beats, so deletes can find them again
    logic [HANDLE_W-1:0] stray_handles [$];

    least_load_gate_selector_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_gate_handle   (s_gate_handle),
        .s_gate_port     (s_gate_port),
        .s_gate_load     (s_gate_load),
        .s_conn_id       (s_conn_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_reply_conn    (m_reply_conn),
        .m_chosen_handle (m_chosen_handle),
        .m_chosen_port   (m_chosen_port),
        .m_chosen_load   (m_chosen_load)
    );

    least_load_gate_selector_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_gate_handle   (s_gate_handle),
        .s_gate_port     (s_gate_port),
        .s_gate_load     (s_gate_load),
        .s_conn_id       (s_conn_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_reply_conn    (m_reply_conn),
        .m_chosen_handle (m_chosen_handle),
        .m_chosen_port   (m_chosen_port),
        .m_chosen_load   (m_chosen_load),
        .fail_count      (fail_count),
        .pending         (pending),
        .checked         (checked),
        .n_ok            (n_ok),
        .n_no_server     (n_no_server),
        .n_not_found     (n_not_found),
        .n_full          (n_full)
    );

    // 100 MHz clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit in_pool(input logic [HANDLE_W-1:0] h);
        return 16'(h - pool_base) < POOL_SIZE;
    endfunction

    // offer one beat and hold it until taken, then maybe leave a random gap;
    // with no gap valid simply stays high for the next beat
    task automatic send_beat(input mode_t md, input logic [HANDLE_W-1:0] h,
                             input logic [PORT_W-1:0] port, input logic [LOAD_W-1:0] load,
                             input logic [CONN_W-1:0] conn);
        int gap;
        s_valid       <= 1'b1;
        s_mode        <= md;
        s_gate_handle <= h;
        s_gate_port   <= port;
        s_gate_load   <= load;
        s_conn_id     <= conn;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        if ((md == MODE_SET || md == MODE_UPD) && !in_pool(h) && stray_handles.size() < 64) begin
            stray_handles.push_back(h);
        end
        // after a beat, add idle cycles with an 18 percent chance each, none inside the quiet window
        gap = 0;
        if (!quiet) begin
            while ($urandom_range(99) < 18) gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // random beat; phases alternate between growing the table towards full and
    // draining it towards empty, so both ends of the occupancy are visited
    task automatic send_random(input int idx);
        mode_t               md;
        logic [HANDLE_W-1:0] h;
        logic [LOAD_W-1:0]   load;
        int                  roll;
        bit                  draining;
        draining = ((idx / PHASE_LEN) % 2) == 1;
        roll = $urandom_range(99);
        if (draining) begin
            if (roll < 10)      md = MODE_SET;
            else if (roll < 20) md = MODE_UPD;
            else if (roll < 65) md = MODE_DEL;
            else                md = MODE_REQ;
        end else begin
            if (roll < 35)      md = MODE_SET;
            else if (roll < 60) md = MODE_UPD;
            else if (roll < 70) md = MODE_DEL;
            else                md = MODE_REQ;
        end
        roll = $urandom_range(99);
        if (md == MODE_DEL && stray_handles.size() > 0 && roll < 40) begin
            h = stray_handles.pop_front();
        end else if (roll < 5) begin
            h = 16'($urandom);   // full-range handle, every bit toggles
        end else begin
            h = pool_base + 16'($urandom_range(POOL_SIZE - 1));
        end
        // mostly tiny loads so ties are common, plus the extremes and full range
        roll = $urandom_range(99);
        if (roll < 45)      load = 24'($urandom_range(7));
        else if (roll < 60) load = '0;
        else if (roll < 70) load = '1;
        else                load = 24'($urandom);
        send_beat(md, h, 16'($urandom), load, 20'($urandom));
    endtask

    // result sink: random back-pressure, one long hold-off so the block fills up
    // and stalls its input while the source keeps offering beats
    initial begin : result_sink
        bit held_off;
        held_off = 1'b0;
        @(posedge aclk);
        forever begin
            if (!held_off && beats_sent >= HOLD_AT) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            m_ready <= quiet || ($urandom_range(99) >= 18);
            @(posedge aclk);
        end
    end

    initial begin : stimulus
        pool_base = 16'($urandom);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table: request has no server, delete misses
        send_beat(MODE_REQ, 16'h0000, 16'h0000, 24'h000000, 20'hFFFFF);
        send_beat(MODE_DEL, 16'h0001, 16'h0000, 24'h000000, 20'h00000);
        // field extremes, load update of an absent handle inserts it with port zero
        send_beat(MODE_SET, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 20'h00000);
        send_beat(MODE_SET, 16'h0000, 16'h0000, 24'h000000, 20'hFFFFF);
        send_beat(MODE_UPD, 16'h1234, 16'hFFFF, 24'h000005, 20'h00000);
        // overwrite in place, entry keeps its slot
        send_beat(MODE_SET, 16'hFFFF, 16'hA5A5, 24'h000003, 20'h00000);
        send_beat(MODE_REQ, 16'h0000, 16'h0000, 24'h000000, 20'h00000);
        send_beat(MODE_UPD, 16'h0000, 16'h0000, 24'hFFFFFF, 20'h00000);
        // fill to the top, the last slot gets the smallest load
        for (int k = 0; k < 13; k++) begin
            send_beat(MODE_SET, 16'h0100 + 16'(k), 16'h5A5A ^ 16'(k),
                      (k == 12) ? 24'h000000 : 24'h000010 + 24'(k), 20'h00000);
        end
        // full table refuses new handles in both modes
        send_beat(MODE_SET, 16'h0200, 16'h1111, 24'h000001, 20'h00000);
        send_beat(MODE_UPD, 16'h0201, 16'h0000, 24'h000001, 20'h00000);
        // pick the last slot so the pointer goes past the end, then shrink the table
        // under it: the next scan has to wrap the pointer
        send_beat(MODE_REQ, 16'h0000, 16'h0000, 24'h000000, 20'h5A5A5);
        send_beat(MODE_DEL, 16'h0100, 16'h0000, 24'h000000, 20'h00000);
        send_beat(MODE_REQ, 16'h0000, 16'h0000, 24'h000000, 20'hA5A5A);

        for (int i = 0; i < RANDOM_BEATS; i++) begin
            quiet = (i >= QUIET_FROM) && (i < QUIET_TO);
            send_random(i);
        end
        quiet = 1'b0;
        s_valid <= 1'b0;

        // wait for every reply, then a little longer to catch stray result beats
        while (pending != 0 || checked < beats_sent) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d beats sent, %0d result beats checked", beats_sent, checked);
        $display("replies: %0d ok, %0d empty table, %0d handle missing, %0d table full",
                 n_ok, n_no_server, n_not_found, n_full);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // safety net, far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
